[rtl/core/rrf_pkg.sv]
// Shared types and constants for the ranging report framer.
package rrf_pkg;

  // Word index width: enough for a group of up to 125 words.
  localparam int unsigned IDX_W = 7;

  // Depth of the queue between the front and back parts.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_CW    = 3;

  // Configuration register indexes.
  localparam logic [7:0] CFG_STATION  = 8'd0;
  localparam logic [7:0] CFG_FUNCTION = 8'd1;
  localparam logic [7:0] CFG_TAG      = 8'd2;
  localparam logic [7:0] CFG_KIND     = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_STATION  = 8'h01;
  localparam logic [7:0]  RST_FUNCTION = 8'h03;
  localparam logic [15:0] RST_TAG      = 16'hACDA;
  localparam logic [15:0] RST_KIND     = 16'h0003;

  // CRC-16/MODBUS constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One classified word as it travels from front to back.
  typedef struct packed {
    logic [15:0] word;
    logic        first;
    logic        last;
  } rrf_item_t;

  // Header fields taken from the configuration registers.
  typedef struct packed {
    logic [7:0]  station_address;
    logic [7:0]  function_code;
    logic [15:0] packet_tag;
    logic [15:0] report_kind;
  } rrf_hdr_t;

  // Byte sequencer states of the back part.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_WHI,
    S_WLO,
    S_CLO,
    S_CHI
  } rrf_state_t;

endpackage

[rtl/core/ranging_report_framer_crc16_top.sv]
// Top level of the ranging report framer with CRC-16/MODBUS trailer.
// A word passes through the queue, the byte sequencer state and the output register before its first byte appears.
// Throughput: one frame byte per cycle through the output register while out_stall is low and the queue is not
// empty; a word gives 2 bytes in mid-group, 9 bytes when it opens a group and 4 when it closes one.
// A four-entry queue between the word front end and the byte sequencer absorbs stalls.
// Reset clears the queue and word position, sets the CRC to all ones and loads register defaults.
module ranging_report_framer_crc16_top #(
  parameter int unsigned FRAME_WORDS = 19
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] word_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rrf_pkg::*;

  rrf_hdr_t  hdr;
  rrf_item_t push_item;
  rrf_item_t pop_item;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr.station_address <= RST_STATION;
      hdr.function_code   <= RST_FUNCTION;
      hdr.packet_tag      <= RST_TAG;
      hdr.report_kind     <= RST_KIND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STATION:  hdr.station_address <= cfg_data[7:0];
        CFG_FUNCTION: hdr.function_code   <= cfg_data[7:0];
        CFG_TAG:      hdr.packet_tag      <= cfg_data;
        CFG_KIND:     hdr.report_kind     <= cfg_data;
        default: ;
      endcase
    end
  end

  rrf_front #(
    .FRAME_WORDS(FRAME_WORDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .word_value (word_value),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  rrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  rrf_back #(
    .FRAME_WORDS(FRAME_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .hdr        (hdr),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
  );

endmodule

[rtl/core/rrf_front.sv]
// Front part: accepts report words and marks the first and last word of each group.
module rrf_front #(
  parameter int unsigned FRAME_WORDS = 19
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       word_value,
  input  logic              q_full,
  output logic              q_push,
  output rrf_pkg::rrf_item_t q_item
);
  import rrf_pkg::*;

  // Group length held between two and 125 words.
  localparam int unsigned GROUP_WORDS =
    (FRAME_WORDS < 2) ? 2 : ((FRAME_WORDS > 125) ? 125 : FRAME_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_WORDS - 1);

  logic [IDX_W-1:0] word_index;
  logic [IDX_W-1:0] word_index_next;
  logic             is_last;

  // A word is taken whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign is_last  = (word_index == LAST_IDX);

  assign q_item.word  = word_value;
  assign q_item.first = (word_index == '0);
  assign q_item.last  = is_last;

  // Position within the group wraps after the last word.
  assign word_index_next = is_last ? '0 : word_index + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
    end else if (q_push) begin
      word_index <= word_index_next;
    end
  end

endmodule

[rtl/core/rrf_queue.sv]
// Short queue of classified words between the front and back parts.
module rrf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rrf_pkg::rrf_item_t push_item,
  output logic               full,
  input  logic               pop,
  output rrf_pkg::rrf_item_t pop_item,
  output logic               empty
);
  import rrf_pkg::*;

  rrf_item_t         mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_CW-1:0]   count;

  assign full     = (count == Q_CW'(Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - Q_CW'(1);
      end
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("queue count exceeds depth");

  // No write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  // No read from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

[rtl/core/rrf_back.sv]
// Back part: byte sequencer that emits header, word bytes and CRC through an output register.
module rrf_back #(
  parameter int unsigned FRAME_WORDS = 19
) (
  input  logic               clk,
  input  logic               rst,
  input  rrf_pkg::rrf_hdr_t  hdr,
  input  logic               q_empty,
  input  rrf_pkg::rrf_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         frame_byte,
  output logic               frame_end
);
  import rrf_pkg::*;

  localparam int unsigned GROUP_WORDS =
    (FRAME_WORDS < 2) ? 2 : ((FRAME_WORDS > 125) ? 125 : FRAME_WORDS);
  localparam logic [7:0] LEN_BYTE = 8'(2 * GROUP_WORDS + 4);
  localparam logic [2:0] HDR_LAST = 3'd6;

  // One byte step of the reflected CRC.
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  rrf_state_t  state;
  rrf_state_t  state_next;
  logic [2:0]  hdr_idx;
  logic [2:0]  hdr_idx_next;
  rrf_item_t   cur;
  logic [15:0] crc;
  logic        adv;
  logic        load;
  logic [7:0]  byte_sel;
  logic        end_sel;
  logic        crc_add;
  logic [15:0] crc_base;

  // A byte moves into the output register when it is empty or being drained.
  assign adv   = (state != S_IDLE) && (!out_valid || !out_stall);
  assign q_pop = load;

  // Next state, including loading the next word without a bubble.
  always_comb begin
    state_next   = state;
    hdr_idx_next = hdr_idx;
    load         = 1'b0;
    if (state == S_IDLE) begin
      load = !q_empty;
    end else if (adv) begin
      unique case (state)
        S_HDR: begin
          if (hdr_idx == HDR_LAST) begin
            state_next = S_WHI;
          end else begin
            hdr_idx_next = hdr_idx + 3'd1;
          end
        end
        S_WHI: state_next = S_WLO;
        S_WLO: begin
          if (cur.last) begin
            state_next = S_CLO;
          end else begin
            load       = !q_empty;
            state_next = S_IDLE;
          end
        end
        S_CLO: state_next = S_CHI;
        S_CHI: begin
          load       = !q_empty;
          state_next = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
    if (load) begin
      state_next   = q_item.first ? S_HDR : S_WHI;
      hdr_idx_next = '0;
    end
  end

  // Byte selection and CRC control for the current state.
  always_comb begin
    byte_sel = 8'h00;
    end_sel  = 1'b0;
    crc_add  = 1'b0;
    unique case (state)
      S_HDR: begin
        crc_add = 1'b1;
        case (hdr_idx)
          3'd0:    byte_sel = hdr.station_address;
          3'd1:    byte_sel = hdr.function_code;
          3'd2:    byte_sel = LEN_BYTE;
          3'd3:    byte_sel = hdr.packet_tag[15:8];
          3'd4:    byte_sel = hdr.packet_tag[7:0];
          3'd5:    byte_sel = hdr.report_kind[15:8];
          default: byte_sel = hdr.report_kind[7:0];
        endcase
      end
      S_WHI: begin
        crc_add  = 1'b1;
        byte_sel = cur.word[15:8];
      end
      S_WLO: begin
        crc_add  = 1'b1;
        byte_sel = cur.word[7:0];
      end
      S_CLO: byte_sel = crc[7:0];
      S_CHI: begin
        byte_sel = crc[15:8];
        end_sel  = 1'b1;
      end
      default: byte_sel = 8'h00;
    endcase
  end

  // A new frame starts its CRC from the initial value.
  assign crc_base = (state == S_HDR && hdr_idx == '0) ? CRC_INIT : crc;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      hdr_idx <= '0;
    end else begin
      state   <= state_next;
      hdr_idx <= hdr_idx_next;
    end
  end

  // Current word and running CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (adv && crc_add) begin
      crc <= crc_step(crc_base, byte_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_item;
    end
  end

  // Output register: holds a byte until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame_byte <= byte_sel;
      frame_end  <= end_sel;
    end
  end

  // The header is only sent for the first word of a group.
  a_hdr_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_HDR) |-> cur.first)
    else $error("header emitted for a word that does not start a group");

  // CRC bytes only follow the last word of a group.
  a_crc_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLO || state == S_CHI) |-> cur.last)
    else $error("CRC emitted for a word that does not end a group");

  // Sending the high CRC byte flags the end of the frame.
  a_end_flag: assert property (@(posedge clk) disable iff (rst)
    (adv && state == S_CHI) |=> (out_valid && frame_end))
    else $error("final CRC byte not flagged");

endmodule
